// ===== src/sha256_single_block_hash_core_defines.svh =====
// ----------------------------------------------------------------------------
// SHA-256 single block hash core: assertion macros
// Shared concurrent check helpers, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SHA256_SINGLE_BLOCK_HASH_CORE_DEFINES_SVH
`define SHA256_SINGLE_BLOCK_HASH_CORE_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define SHA_ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define SHA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== src/sha256_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-256 package
// Schedule queue entry type, message limits and the SHA-256 round functions.
// ----------------------------------------------------------------------------
`default_nettype none

package sha256_pkg;

   // Longest message that fits one padded block, and the padding marker
   localparam logic [5:0] MAX_MSG_BYTES = 6'd55;
   localparam logic [7:0] PAD_BYTE      = 8'h80;

   // One big-endian message word on its way to the compression engine
   typedef struct packed {
      logic        overflow;
      logic [31:0] word;
   } sched_word_type;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic logic [31:0] init_hash(input logic [2:0] idx);
      case (idx)
         3'd0:    init_hash = 32'h6a09e667;
         3'd1:    init_hash = 32'hbb67ae85;
         3'd2:    init_hash = 32'h3c6ef372;
         3'd3:    init_hash = 32'ha54ff53a;
         3'd4:    init_hash = 32'h510e527f;
         3'd5:    init_hash = 32'h9b05688c;
         3'd6:    init_hash = 32'h1f83d9ab;
         default: init_hash = 32'h5be0cd19;
      endcase
   endfunction

   function automatic logic [31:0] round_k(input logic [5:0] idx);
      case (idx)
         6'd0:    round_k = 32'h428a2f98;
         6'd1:    round_k = 32'h71374491;
         6'd2:    round_k = 32'hb5c0fbcf;
         6'd3:    round_k = 32'he9b5dba5;
         6'd4:    round_k = 32'h3956c25b;
         6'd5:    round_k = 32'h59f111f1;
         6'd6:    round_k = 32'h923f82a4;
         6'd7:    round_k = 32'hab1c5ed5;
         6'd8:    round_k = 32'hd807aa98;
         6'd9:    round_k = 32'h12835b01;
         6'd10:   round_k = 32'h243185be;
         6'd11:   round_k = 32'h550c7dc3;
         6'd12:   round_k = 32'h72be5d74;
         6'd13:   round_k = 32'h80deb1fe;
         6'd14:   round_k = 32'h9bdc06a7;
         6'd15:   round_k = 32'hc19bf174;
         6'd16:   round_k = 32'he49b69c1;
         6'd17:   round_k = 32'hefbe4786;
         6'd18:   round_k = 32'h0fc19dc6;
         6'd19:   round_k = 32'h240ca1cc;
         6'd20:   round_k = 32'h2de92c6f;
         6'd21:   round_k = 32'h4a7484aa;
         6'd22:   round_k = 32'h5cb0a9dc;
         6'd23:   round_k = 32'h76f988da;
         6'd24:   round_k = 32'h983e5152;
         6'd25:   round_k = 32'ha831c66d;
         6'd26:   round_k = 32'hb00327c8;
         6'd27:   round_k = 32'hbf597fc7;
         6'd28:   round_k = 32'hc6e00bf3;
         6'd29:   round_k = 32'hd5a79147;
         6'd30:   round_k = 32'h06ca6351;
         6'd31:   round_k = 32'h14292967;
         6'd32:   round_k = 32'h27b70a85;
         6'd33:   round_k = 32'h2e1b2138;
         6'd34:   round_k = 32'h4d2c6dfc;
         6'd35:   round_k = 32'h53380d13;
         6'd36:   round_k = 32'h650a7354;
         6'd37:   round_k = 32'h766a0abb;
         6'd38:   round_k = 32'h81c2c92e;
         6'd39:   round_k = 32'h92722c85;
         6'd40:   round_k = 32'ha2bfe8a1;
         6'd41:   round_k = 32'ha81a664b;
         6'd42:   round_k = 32'hc24b8b70;
         6'd43:   round_k = 32'hc76c51a3;
         6'd44:   round_k = 32'hd192e819;
         6'd45:   round_k = 32'hd6990624;
         6'd46:   round_k = 32'hf40e3585;
         6'd47:   round_k = 32'h106aa070;
         6'd48:   round_k = 32'h19a4c116;
         6'd49:   round_k = 32'h1e376c08;
         6'd50:   round_k = 32'h2748774c;
         6'd51:   round_k = 32'h34b0bcb5;
         6'd52:   round_k = 32'h391c0cb3;
         6'd53:   round_k = 32'h4ed8aa4a;
         6'd54:   round_k = 32'h5b9cca4f;
         6'd55:   round_k = 32'h682e6ff3;
         6'd56:   round_k = 32'h748f82ee;
         6'd57:   round_k = 32'h78a5636f;
         6'd58:   round_k = 32'h84c87814;
         6'd59:   round_k = 32'h8cc70208;
         6'd60:   round_k = 32'h90befffa;
         6'd61:   round_k = 32'ha4506ceb;
         6'd62:   round_k = 32'hbef9a3f7;
         default: round_k = 32'hc67178f2;
      endcase
   endfunction

endpackage

`default_nettype wire

// ===== src/sha256_front.sv =====
// ----------------------------------------------------------------------------
// SHA-256 message front end
// Packs message bytes into big-endian words, drops bytes past the block
// limit, and appends the 0x80 marker, zero fill and bit length per message.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sha256_single_block_hash_core_defines.svh"

module sha256_front
   import sha256_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_tvalid,
   output      logic           req_tready,
   input  wire logic [7:0]     req_tdata,   // [7:0] msg_byte
   input  wire logic           req_tuser,   // [0] has_byte
   input  wire logic           req_tlast,   // last_byte
   input  wire logic           fifo_full,
   output      logic           push,
   output      sched_word_type push_entry
);

   localparam logic ST_ACCEPT = 1'b0;
   localparam logic ST_PAD    = 1'b1;

   logic        state_ff, state_in;
   logic [5:0]  count_ff, count_in;
   logic        ovf_ff, ovf_in;
   logic [23:0] acc_ff, acc_in;
   logic [3:0]  pad_idx_ff, pad_idx_in;

   logic        accept;
   logic        store;
   logic [5:0]  count_next;
   logic [31:0] pad_word;

   assign req_tready = (state_ff == ST_ACCEPT) && !fifo_full;
   assign accept     = req_tvalid && req_tready;
   assign store      = accept && req_tuser && (count_ff < MAX_MSG_BYTES);
   assign count_next = store ? count_ff + 6'd1 : count_ff;

   // Build the padding word at the current pad position
   always_comb begin
      pad_word = 32'd0;
      if (pad_idx_ff == count_ff[5:2]) begin
         case (count_ff[1:0])
            2'd0:    pad_word = {PAD_BYTE, 24'd0};
            2'd1:    pad_word = {acc_ff[7:0], PAD_BYTE, 16'd0};
            2'd2:    pad_word = {acc_ff[15:0], PAD_BYTE, 8'd0};
            default: pad_word = {acc_ff[23:0], PAD_BYTE};
         endcase
      end else if (pad_idx_ff == 4'd15) begin
         pad_word = {23'd0, count_ff, 3'd0};
      end
   end

   // Drive the queue: full message words while accepting, pad words after
   always_comb begin
      if (state_ff == ST_ACCEPT) begin
         push            = store && (count_ff[1:0] == 2'd3);
         push_entry.word = {acc_ff, req_tdata};
      end else begin
         push            = !fifo_full;
         push_entry.word = pad_word;
      end
      push_entry.overflow = ovf_ff;
   end

   // Advance the state, byte count, overflow flag, partial word and pad pointer
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      ovf_in     = ovf_ff;
      acc_in     = acc_ff;
      pad_idx_in = pad_idx_ff;
      case (state_ff)
         ST_ACCEPT: begin
            if (store) begin
               acc_in = {acc_ff[15:0], req_tdata};
            end
            if (accept && req_tuser && !store) begin
               ovf_in = 1'b1;
            end
            count_in = count_next;
            if (accept && req_tlast) begin
               state_in   = ST_PAD;
               pad_idx_in = count_next[5:2];
            end
         end
         ST_PAD: begin
            if (push) begin
               pad_idx_in = pad_idx_ff + 4'd1;
               if (pad_idx_ff == 4'd15) begin
                  state_in = ST_ACCEPT;
                  count_in = 6'd0;
                  ovf_in   = 1'b0;
               end
            end
         end
         default: state_in = ST_ACCEPT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_ACCEPT;
         count_ff   <= 6'd0;
         ovf_ff     <= 1'b0;
         pad_idx_ff <= 4'd0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         ovf_ff     <= ovf_in;
         pad_idx_ff <= pad_idx_in;
      end
   end

   // Hold the partial word bytes
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   `SHA_ASSERT_IMPLIES(a_push_not_full, push, !fifo_full)
   `SHA_ASSERT_NEXT(a_last_starts_pad, req_tvalid && req_tready && req_tlast, state_ff == ST_PAD)

endmodule

`default_nettype wire

// ===== src/sha256_word_fifo.sv =====
// ----------------------------------------------------------------------------
// SHA-256 schedule word queue
// Small register FIFO between the front end and the compression engine.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sha256_single_block_hash_core_defines.svh"

module sha256_word_fifo
   import sha256_pkg::*;
#(
   parameter int DEPTH = 4   // at least 2
)
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push,
   input  wire sched_word_type push_entry,
   input  wire logic           pop,
   output      sched_word_type pop_entry,
   output      logic           full,
   output      logic           empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   sched_word_type          entries_ff [DEPTH];
   logic [PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]        count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign pop_entry = entries_ff[rd_ptr_ff];

   // Advance pointers with wrap and track the fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed beat
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `SHA_ASSERT_IMPLIES(a_no_pop_when_empty, pop, count_ff != '0)

endmodule

`default_nettype wire

// ===== src/sha256_back.sv =====
// ----------------------------------------------------------------------------
// SHA-256 compression engine
// Loads sixteen block words, runs 64 rounds with a rolling schedule, then
// emits the eight digest words through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sha256_single_block_hash_core_defines.svh"

module sha256_back
   import sha256_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           fifo_empty,
   input  wire sched_word_type fifo_entry,
   output      logic           pop,
   output      logic           rsp_tvalid,
   input  wire logic           rsp_tready,
   output      logic [31:0]    rsp_tdata,   // [31:0] digest_word
   output      logic [3:0]     rsp_tuser,   // [2:0] word_index, [3] too_long
   output      logic           rsp_tlast    // last_word
);

   localparam logic [1:0] ST_LOAD  = 2'd0;
   localparam logic [1:0] ST_ROUND = 2'd1;
   localparam logic [1:0] ST_OUT   = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic [3:0]  load_cnt_ff, load_cnt_in;
   logic [5:0]  round_ff, round_in;
   logic [2:0]  out_idx_ff, out_idx_in;
   logic        ovf_ff, ovf_in;
   logic [31:0] sched_ff [16];
   logic [31:0] sched_in [16];
   logic [31:0] vars_ff [8];
   logic [31:0] vars_in [8];

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff, rsp_data_in;
   logic [3:0]  rsp_user_ff, rsp_user_in;
   logic        rsp_last_ff, rsp_last_in;

   logic [31:0] t1, t2, new_w;
   logic        load_out;

   assign pop      = (state_ff == ST_LOAD) && !fifo_empty;
   assign load_out = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_tready);

   // One SHA-256 round and the next schedule word
   always_comb begin
      t1 = round_k(round_ff) + big_sigma1(vars_ff[4])
         + ((vars_ff[4] & vars_ff[5]) ^ (~vars_ff[4] & vars_ff[6]))
         + vars_ff[7] + sched_ff[0];
      t2 = big_sigma0(vars_ff[0])
         + ((vars_ff[0] & vars_ff[1]) ^ (vars_ff[0] & vars_ff[2])
            ^ (vars_ff[1] & vars_ff[2]));
      new_w = small_sigma1(sched_ff[14]) + sched_ff[9]
            + small_sigma0(sched_ff[1]) + sched_ff[0];
   end

   // Sequence load, rounds and digest output
   always_comb begin
      state_in    = state_ff;
      load_cnt_in = load_cnt_ff;
      round_in    = round_ff;
      out_idx_in  = out_idx_ff;
      ovf_in      = ovf_ff;
      sched_in    = sched_ff;
      vars_in     = vars_ff;
      case (state_ff)
         ST_LOAD: begin
            if (pop) begin
               for (int i = 0; i < 15; i++) begin
                  sched_in[i] = sched_ff[i + 1];
               end
               sched_in[15] = fifo_entry.word;
               load_cnt_in  = load_cnt_ff + 4'd1;
               if (load_cnt_ff == 4'd15) begin
                  state_in = ST_ROUND;
                  round_in = 6'd0;
                  ovf_in   = fifo_entry.overflow;
                  for (int i = 0; i < 8; i++) begin
                     vars_in[i] = init_hash(3'(i));
                  end
               end
            end
         end
         ST_ROUND: begin
            for (int i = 0; i < 15; i++) begin
               sched_in[i] = sched_ff[i + 1];
            end
            sched_in[15] = new_w;
            vars_in[7]   = vars_ff[6];
            vars_in[6]   = vars_ff[5];
            vars_in[5]   = vars_ff[4];
            vars_in[4]   = vars_ff[3] + t1;
            vars_in[3]   = vars_ff[2];
            vars_in[2]   = vars_ff[1];
            vars_in[1]   = vars_ff[0];
            vars_in[0]   = t1 + t2;
            round_in     = round_ff + 6'd1;
            if (round_ff == 6'd63) begin
               state_in   = ST_OUT;
               out_idx_in = 3'd0;
            end
         end
         ST_OUT: begin
            if (load_out) begin
               out_idx_in = out_idx_ff + 3'd1;
               if (out_idx_ff == 3'd7) begin
                  state_in = ST_LOAD;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // Fill the output register or drop a taken beat
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = vars_ff[out_idx_ff] + init_hash(out_idx_ff);
         rsp_user_in  = {ovf_ff, out_idx_ff};
         rsp_last_in  = (out_idx_ff == 3'd7);
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         load_cnt_ff  <= 4'd0;
         round_ff     <= 6'd0;
         out_idx_ff   <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         load_cnt_ff  <= load_cnt_in;
         round_ff     <= round_in;
         out_idx_ff   <= out_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold datapath contents
   always_ff @(posedge clock) begin
      ovf_ff      <= ovf_in;
      sched_ff    <= sched_in;
      vars_ff     <= vars_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   `SHA_ASSERT_NEXT(a_rounds_end_in_out, (state_ff == ST_ROUND) && (round_ff == 6'd63), state_ff == ST_OUT)
   `SHA_ASSERT_NEXT(a_block_starts_rounds, pop && (load_cnt_ff == 4'd15), (state_ff == ST_ROUND) && (round_ff == 6'd0))
   `SHA_ASSERT_IMPLIES(a_no_pop_outside_load, (state_ff == ST_ROUND) || (state_ff == ST_OUT), !pop)

endmodule

`default_nettype wire

// ===== src/sha256_single_block_hash_core.sv =====
// ----------------------------------------------------------------------------
// SHA-256 single block hash core
// Hashes a message of up to 55 bytes fed one byte per beat and returns the
// eight digest words, most significant first.
//
// Input channel req_*: one beat per message byte; req_tuser marks a valid
// byte, req_tlast ends the message (an empty-byte beat with tlast ends it
// without a byte; an empty-byte beat without tlast does nothing). Bytes past
// the 55th are dropped and flagged as too_long on every digest word.
// Bytes are taken one per cycle while the word queue has room. After tlast
// the front end appends the 0x80 marker, zero fill and bit length as
// padding words, and stalls input meanwhile.
// The compression engine loads the block from the queue, runs the 64 rounds
// (one round per cycle) and then emits the digest words; it takes no word
// of the next message from the queue until the last digest word of the
// current one has gone into the output register.
// Output channel rsp_*: eight beats per message, tlast on the eighth. An
// output register holds a stalled word; the engine stops until it is taken,
// while the front end keeps accepting the next message into the queue.
// Reset clears all control state; no results are pending after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_single_block_hash_core
   import sha256_pkg::*;
#(
   parameter int FIFO_DEPTH = 4
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] msg_byte
   input  wire logic        req_tuser,   // [0] has_byte
   input  wire logic        req_tlast,   // last_byte
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [31:0] rsp_tdata,   // [31:0] digest_word
   output      logic [3:0]  rsp_tuser,   // [2:0] word_index, [3] too_long
   output      logic        rsp_tlast    // last_word
);

   logic           fifo_full;
   logic           fifo_empty;
   logic           push;
   logic           pop;
   sched_word_type push_entry;
   sched_word_type pop_entry;

   sha256_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .fifo_full  (fifo_full),
      .push       (push),
      .push_entry (push_entry)
   );

   sha256_word_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .full       (fifo_full),
      .empty      (fifo_empty)
   );

   sha256_back u_back (
      .clock      (clock),
      .reset      (reset),
      .fifo_empty (fifo_empty),
      .fifo_entry (pop_entry),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-256 single block hash core testbench
// Feeds messages one byte per beat: first a short directed table, then random
// messages of random length, including ones past the 55-byte limit. Sender
// and receiver idle and stall at random. Each digest beat is compared field
// by field with the oldest due word, typed in or from a local SHA-256 model.
// ----------------------------------------------------------------------------

module tb_top;
   import sha256_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int RANDOM_ITEMS  = 200;
   localparam int DRAIN_CYCLES  = 120;
   localparam int NUM_DIRECTED  = 14;

   localparam logic [255:0] EMPTY_DIGEST =
      256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
   localparam logic [255:0] ABC_DIGEST =
      256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;

   localparam logic [31:0] SHA_IV [0:7] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] SHA_K [0:63] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   // One row of the directed table; digest is typed in only where known
   typedef struct packed {
      logic [7:0]   data;
      logic         has;
      logic         last;
      logic         known;
      logic [255:0] digest;
   } dir_step_type;

   // One digest beat as the core should return it
   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
      logic        too_long;
   } digest_beat_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] msg_byte
   logic        req_tuser  = 1'b0;    // [0] has_byte
   logic        req_tlast  = 1'b0;    // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;            // [31:0] digest_word
   logic [3:0]  rsp_tuser;            // [2:0] word_index, [3] too_long
   logic        rsp_tlast;            // last_word

   digest_beat_type digest_words_due [$];
   logic [7:0]      held_bytes [0:63];
   int              held_count;
   bit              held_dropped;
   int              mismatch_count;
   int              cycle_count;
   int              counted_items;
   int              burst_left;
   bit              tx_no_gaps;
   int              rx_mode;
   int              rx_phase_left;
   int              rx_stall_left;
   dir_step_type    dir_steps [0:NUM_DIRECTED-1];

   sha256_single_block_hash_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[sha256_single_block_hash_core] ERROR");
         $finish;
      end
   end

   // Rotate right by doubling the word and taking a slice
   function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
      logic [63:0] dbl;
      dbl = {x, x};
      return dbl[n +: 32];
   endfunction

   // Full SHA-256 compression of one padded block from the initial hash
   function automatic logic [255:0] sha256_block_digest(input logic [511:0] blk);
      logic [31:0] w [0:63];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
      int r;
      for (r = 0; r < 16; r++) begin
         w[r] = blk[511 - 32*r -: 32];
      end
      for (r = 16; r < 64; r++) begin
         s0 = ror32(w[r-15], 7) ^ ror32(w[r-15], 18) ^ (w[r-15] >> 3);
         s1 = ror32(w[r-2], 17) ^ ror32(w[r-2], 19) ^ (w[r-2] >> 10);
         w[r] = w[r-16] + s0 + w[r-7] + s1;
      end
      a = SHA_IV[0]; b = SHA_IV[1]; c = SHA_IV[2]; d = SHA_IV[3];
      e = SHA_IV[4]; f = SHA_IV[5]; g = SHA_IV[6]; h = SHA_IV[7];
      for (r = 0; r < 64; r++) begin
         t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
              + SHA_K[r] + w[r];
         t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1;
         d = c; c = b; b = a; a = t1 + t2;
      end
      return {a + SHA_IV[0], b + SHA_IV[1], c + SHA_IV[2], d + SHA_IV[3],
              e + SHA_IV[4], f + SHA_IV[5], g + SHA_IV[6], h + SHA_IV[7]};
   endfunction

   // Store an accepted byte; at message end pad, hash and queue eight words
   task automatic absorb_msg_beat(input logic [7:0] data, input logic has,
                                  input logic last, input logic known,
                                  input logic [255:0] typed);
      logic [511:0] blk;
      logic [255:0] dig;
      digest_beat_type beat;
      int i;
      if (has) begin
         if (held_count < MAX_MSG_BYTES) begin
            held_bytes[held_count] = data;
            held_count++;
         end else begin
            held_dropped = 1'b1;
         end
      end
      if (!last) return;
      blk = '0;
      for (i = 0; i < held_count; i++) begin
         blk[511 - 8*i -: 8] = held_bytes[i];
      end
      blk[511 - 8*held_count -: 8] = PAD_BYTE;
      blk[63:0] = 64'(held_count) * 64'd8;
      dig = known ? typed : sha256_block_digest(blk);
      for (i = 0; i < 8; i++) begin
         beat.word     = dig[255 - 32*i -: 32];
         beat.index    = 3'(i);
         beat.last     = (i == 7);
         beat.too_long = held_dropped;
         digest_words_due.push_back(beat);
      end
      held_count   = 0;
      held_dropped = 1'b0;
   endtask

   // Print one line per mismatch and count it
   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      $display("mismatch %s: got %h, want %h (cycle %0d)", what, got, want, cycle_count);
      mismatch_count++;
   endtask

   // Drive one beat at the falling edge and hold it until accepted
   task automatic send_beat(input logic [7:0] data, input logic has, input logic last,
                            input logic known, input logic [255:0] typed);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= has;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      absorb_msg_beat(data, has, last, known, typed);
      if (has || last) counted_items++;
   endtask

   // Drop valid for a number of cycles, scrambling the idle data
   task automatic idle_cycles(input int n);
      repeat (n) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         req_tdata  <= 8'($urandom);
      end
   endtask

   // Sender pacing: bursts of random length split by random gaps, unless tx_no_gaps is set
   task automatic pace_sender();
      if (burst_left == 0) begin
         if (!tx_no_gaps) idle_cycles($urandom_range(1, 8));
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
   endtask

   // One random message; noise beats inside, end by last byte or empty beat
   task automatic send_random_message(input int len);
      bit empty_end;
      int i;
      empty_end = (len == 0) || ($urandom_range(0, 3) == 0);
      for (i = 0; i < len; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            pace_sender();
            send_beat(8'($urandom), 1'b0, 1'b0, 1'b0, '0);
         end
         pace_sender();
         send_beat(8'($urandom), 1'b1, (i == len - 1) && !empty_end, 1'b0, '0);
      end
      if (empty_end) begin
         pace_sender();
         send_beat(8'($urandom), 1'b0, 1'b1, 1'b0, '0);
      end
   endtask

   // Receiver: change stall style now and then, including stall-free stretches
   always @(negedge clock) begin
      if (rx_phase_left == 0) begin
         rx_mode       = $urandom_range(0, 2);
         rx_phase_left = $urandom_range(50, 300);
      end
      rx_phase_left--;
      if (rx_stall_left > 0) begin
         rx_stall_left--;
         rsp_tready <= 1'b0;
      end else if (rx_mode == 1) begin
         rsp_tready <= 1'($urandom_range(0, 1));
      end else if (rx_mode == 2 && $urandom_range(0, 15) == 0) begin
         rx_stall_left = $urandom_range(3, 20);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Check each accepted digest beat against the oldest expected word
   always @(posedge clock) begin : check_rsp
      digest_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (digest_words_due.size() == 0) begin
            flag_mismatch("unexpected beat", rsp_tdata, 32'h0);
         end else begin
            want = digest_words_due.pop_front();
            if (rsp_tdata !== want.word)
               flag_mismatch("digest_word", rsp_tdata, want.word);
            if (rsp_tuser[2:0] !== want.index)
               flag_mismatch("word_index", 32'(rsp_tuser[2:0]), 32'(want.index));
            if (rsp_tlast !== want.last)
               flag_mismatch("last_word", 32'(rsp_tlast), 32'(want.last));
            if (rsp_tuser[3] !== want.too_long)
               flag_mismatch("too_long", 32'(rsp_tuser[3]), 32'(want.too_long));
         end
      end
   end

   // Stimulus and end of run
   initial begin
      int k;
      int len;
      held_count    = 0;
      held_dropped  = 1'b0;
      rx_mode       = 0;
      rx_phase_left = 0;
      rx_stall_left = 0;
      burst_left    = 0;
      tx_no_gaps    = 1'b0;
      dir_steps = '{
         '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},   // empty message
         '{8'h5a, 1'b0, 1'b0, 1'b0, 256'h0},         // idle beat, no effect
         '{8'h61, 1'b1, 1'b0, 1'b0, 256'h0},         // "abc"
         '{8'h62, 1'b1, 1'b0, 1'b0, 256'h0},
         '{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},
         '{8'h00, 1'b1, 1'b0, 1'b0, 256'h0},         // zero byte is ordinary
         '{8'hff, 1'b1, 1'b0, 1'b0, 256'h0},
         '{8'ha5, 1'b0, 1'b0, 1'b0, 256'h0},         // idle inside a message
         '{8'h00, 1'b0, 1'b1, 1'b0, 256'h0},         // empty end after bytes
         '{8'hff, 1'b1, 1'b1, 1'b0, 256'h0},
         '{8'h00, 1'b1, 1'b1, 1'b0, 256'h0},
         '{8'h01, 1'b1, 1'b0, 1'b0, 256'h0},
         '{8'h80, 1'b1, 1'b1, 1'b0, 256'h0},         // byte equal to the pad marker
         '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST}    // empty message again
      };

      // Hold reset, then release it at a falling edge
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Walk the directed table
      for (k = 0; k < NUM_DIRECTED; k++) begin
         pace_sender();
         send_beat(dir_steps[k].data, dir_steps[k].has, dir_steps[k].last,
                   dir_steps[k].known, dir_steps[k].digest);
      end

      // Hold off until every digest word has come back
      idle_cycles(1);
      while (digest_words_due.size() != 0) @(posedge clock);

      // Random messages: limit and overflow lengths first, then mostly short ones
      counted_items = 0;
      k = 0;
      while (counted_items < RANDOM_ITEMS) begin
         tx_no_gaps = ($urandom_range(0, 3) == 0);
         if (k == 0)                          len = MAX_MSG_BYTES;
         else if (k == 1)                     len = MAX_MSG_BYTES + 2;
         else if ($urandom_range(0, 9) == 0)  len = $urandom_range(48, 70);
         else if ($urandom_range(0, 7) == 0)  len = 0;
         else                                 len = $urandom_range(1, 12);
         send_random_message(len);
         if ($urandom_range(0, 5) == 0) begin
            idle_cycles(1);
            while (digest_words_due.size() != 0) @(posedge clock);
         end
         k++;
      end
      idle_cycles(1);

      // Drain, then allow for stray beats
      while (digest_words_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[sha256_single_block_hash_core] OK");
      end else begin
         $display("[sha256_single_block_hash_core] ERROR");
      end
      $finish;
   end

endmodule
